FILE: rtl/khrb_pkg.sv
// Package of shared constants, types and helper functions for the keyed history ring buffer.
`timescale 1ns / 1ps

package khrb_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int CHANNEL_COUNT = 4;
  localparam int VALUE_WIDTH   = 32;

  localparam int KEY_REGS = 4;
  localparam int MAX_OUT  = 16;

  localparam int KEY_W    = 16;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int CIU_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int STORE_DEPTH = CHANNEL_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ARITH_W = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;
  localparam int LOOKUP_CH = (CHANNEL_COUNT < KEY_REGS) ? CHANNEL_COUNT : KEY_REGS;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = CFG_IDX_W'(KEY_REGS);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_VALUE  = 2'd0,
    STATUS_NO_KEY = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef logic [KEY_W-1:0] key_t;
  typedef key_t [KEY_REGS-1:0] key_bank_t;

  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } match_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                  input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(ch) * ADDR_W'(HISTORY_DEPTH)) + ADDR_W'(s);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [SAMPLE_W-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] from_store(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/khrb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module khrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/khrb_match.sv
// Key lookup over the channels in use, lowest channel first.
`timescale 1ns / 1ps

module khrb_match (
  input  khrb_pkg::key_t                  key_i,
  input  khrb_pkg::key_bank_t             keys_i,
  input  logic [khrb_pkg::CIU_W-1:0]      channels_in_use_i,
  output khrb_pkg::match_t                match_o
);
  import khrb_pkg::*;

  always_comb begin
    match_o = '0;
    for (int i = LOOKUP_CH - 1; i >= 0; i--) begin
      if ((channels_in_use_i > CIU_W'(i)) && (keys_i[i] == key_i)) begin
        match_o.hit = 1'b1;
        match_o.ch  = CH_W'(i);
      end
    end
  end

endmodule

FILE: rtl/keyed_history_ring_buffer_top.sv
// Top level of the keyed history ring buffer: channel state, dump sequencer and store.
//
//   channel   direction  handshake                    beat
//   item      in         start_i & !busy_o            kind, key, sample_value, count
//   result    out        result_valid_o (strobe)      status, position, history_value, last
//   config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// A save beat's key is matched and its value written in the accept cycle.
// A dump of n values holds busy_o while it reads, one store read per cycle through the single
// read port, and each result follows in the cycle after its read; a miss or an empty ring
// gives its single result in the cycle after acceptance.
// Reset clears the keys, the channel count, every ring's fill count and newest slot; the
// store itself is not cleared. The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps

module keyed_history_ring_buffer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [khrb_pkg::KEY_W-1:0]        key_i,
  input  logic signed [khrb_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [khrb_pkg::COUNT_W-1:0]      count_i,
  output logic                              result_valid_o,
  output logic [khrb_pkg::STATUS_W-1:0]     status_o,
  output logic [khrb_pkg::POS_W-1:0]        position_o,
  output logic signed [khrb_pkg::SAMPLE_W-1:0] history_value_o,
  output logic                              last_of_dump_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [khrb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [khrb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import khrb_pkg::*;

  key_bank_t          keys_q;
  logic [CIU_W-1:0]   ciu_q;
  logic [SLOT_W-1:0]  newest_q [CHANNEL_COUNT];
  logic [FILL_W-1:0]  fill_q [CHANNEL_COUNT];

  state_e             state_q, state_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   n_q, n_d;

  logic               res_valid_q, res_valid_d;
  status_e            res_status_q, res_status_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  logic               res_last_q, res_last_d;

  logic               save_en;
  logic [SLOT_W-1:0]  save_slot;
  logic [FILL_W-1:0]  save_fill;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  match_t             match;
  logic               accept;
  logic [SLOT_W-1:0]  cur_newest;
  logic [FILL_W-1:0]  cur_fill;
  logic [ARITH_W-1:0] want, n_a, newest_p1, start_a;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q == ST_DUMP);
  assign accept      = start_i && !busy_o;

  khrb_match u_match (
    .key_i             (key_i),
    .keys_i            (keys_q),
    .channels_in_use_i (ciu_q),
    .match_o           (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
      ciu_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_CHANNELS_IN_USE) begin
        ciu_q <= cfg_data_i[CIU_W-1:0];
      end
      for (int i = 0; i < KEY_REGS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) begin
          keys_q[i] <= cfg_data_i[KEY_W-1:0];
        end
      end
    end
  end

  assign cur_newest = newest_q[match.ch];
  assign cur_fill   = fill_q[match.ch];

  always_comb begin
    save_en   = accept && !kind_i && match.hit;
    save_slot = '0;
    save_fill = FILL_W'(1);
    if (cur_fill != '0) begin
      save_slot = next_slot(cur_newest);
      save_fill = (cur_fill < FILL_W'(HISTORY_DEPTH)) ? cur_fill + FILL_W'(1) : cur_fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        newest_q[i] <= '0;
        fill_q[i]   <= '0;
      end
    end else if (save_en) begin
      newest_q[match.ch] <= save_slot;
      fill_q[match.ch]   <= save_fill;
    end
  end

  assign ram_we    = save_en;
  assign ram_waddr = slot_addr(match.ch, save_slot);

  always_comb begin
    want = (count_i == '0) ? ARITH_W'(1) : ARITH_W'(count_i);
    n_a  = (want < ARITH_W'(cur_fill)) ? want : ARITH_W'(cur_fill);
    if (n_a > ARITH_W'(MAX_OUT)) begin
      n_a = ARITH_W'(MAX_OUT);
    end
    newest_p1 = ARITH_W'(cur_newest) + ARITH_W'(1);
    if (newest_p1 >= n_a) begin
      start_a = newest_p1 - n_a;
    end else begin
      start_a = newest_p1 + ARITH_W'(HISTORY_DEPTH) - n_a;
    end
  end

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    slot_d       = slot_q;
    pos_d        = pos_q;
    n_d          = n_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_last_d   = res_last_q;
    ram_re       = 1'b0;
    ram_raddr    = slot_addr(ch_q, slot_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind_i) begin
          if (!match.hit || cur_fill == '0) begin
            res_valid_d  = 1'b1;
            res_status_d = match.hit ? STATUS_EMPTY : STATUS_NO_KEY;
            res_pos_d    = '0;
            res_last_d   = 1'b1;
          end else begin
            state_d = ST_DUMP;
            ch_d    = match.ch;
            slot_d  = start_a[SLOT_W-1:0];
            pos_d   = POS_W'(1);
            n_d     = n_a[POS_W-1:0];
          end
        end
      end
      ST_DUMP: begin
        ram_re       = 1'b1;
        res_valid_d  = 1'b1;
        res_status_d = STATUS_VALUE;
        res_pos_d    = pos_q;
        res_last_d   = (pos_q == n_q);
        slot_d       = next_slot(slot_q);
        pos_d        = pos_q + POS_W'(1);
        if (pos_q == n_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q         <= ch_d;
    slot_q       <= slot_d;
    pos_q        <= pos_d;
    n_q          <= n_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_last_q   <= res_last_d;
  end

  khrb_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (to_store(sample_value_i)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign position_o      = res_pos_q;
  assign last_of_dump_o  = res_last_q;
  assign history_value_o = (res_status_q == STATUS_VALUE) ? from_store(ram_rdata) : '0;

`ifndef NO_ASSERTIONS
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> fill_q[ch_q] != '0 && n_q <= POS_W'(fill_q[ch_q]) &&
                           n_q != '0)
    else $error("dump runs over an empty ring or beyond its fill");

  a_no_write_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_IDLE)
    else $error("store written while a dump is reading");

  a_dump_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_dump_o |=>
      result_valid_o && position_o == $past(position_o) + POS_W'(1))
    else $error("dump results are not contiguous");

  a_new_dump_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_dump_o |=> !result_valid_o || position_o <= POS_W'(1))
    else $error("result after the last of a dump does not open a new one");
`endif

endmodule
